[hw/rtl/udp_pdt_pkg.sv]
// Types and constants of the UDP port demux table.
// Used by every module of the block; depends on nothing.
package udp_pdt_pkg;

  localparam int unsigned PortW = 16;
  localparam int unsigned DestW = 8;
  localparam int unsigned AddrW = 32;
  localparam int unsigned LenW  = 16;
  localparam int unsigned SlotW = 5;

  localparam logic [LenW-1:0] HdrBytes = LenW'(8);

  typedef enum logic [1:0] {
    CMD_BIND    = 2'd0,
    CMD_UNBIND  = 2'd1,
    CMD_DELIVER = 2'd2,
    CMD_RSVD    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_BOUND     = 3'd0,
    ST_REJECTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_UNBOUND   = 3'd3,
    ST_NOT_BOUND = 3'd4,
    ST_DELIVERED = 3'd5,
    ST_MALFORMED = 3'd6
  } status_e;

  typedef struct packed {
    cmd_e             command;
    logic [PortW-1:0] port;
    logic [DestW-1:0] handler_id;
    logic [AddrW-1:0] src_address;
    logic [PortW-1:0] sender_port;
    logic [LenW-1:0]  udp_length;
    logic [LenW-1:0]  packet_length;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [DestW-1:0] destination;
    logic [LenW-1:0]  payload_length;
    logic [AddrW-1:0] out_src_address;
    logic [PortW-1:0] out_sender_port;
    logic [SlotW-1:0] slot;
  } res_t;

  // table write request; the entry index travels beside it
  typedef struct packed {
    logic             en;
    logic             valid;
    logic [PortW-1:0] port;
    logic [DestW-1:0] dest;
  } tbl_wr_t;

endpackage

[hw/rtl/udp_port_demux_table_top.sv]
// Top level of the UDP port demux table: input and result registers.
// Depends on udp_pdt_pkg, udp_pdt_table and udp_pdt_ctrl.
//
// Takes one item per clock cycle (busy stays low) and returns exactly one
// result per item, on res_o with done_o high for one cycle. Each item passes
// from the input register through the parallel port compare over all
// TABLE_ENTRIES entries to the result register; the table update lands at
// the same edge as the result, so the
// next item already sees it. The receiver cannot stall and must take every
// result in its cycle. Entries live in flops; reset clears the valid bits
// at once, so no clearing pass follows reset.
module udp_port_demux_table_top #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  udp_pdt_pkg::req_t req_i,
  output logic              done_o,
  output udp_pdt_pkg::res_t res_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic                          in_valid_q;
  udp_pdt_pkg::req_t             in_q;
  logic                          done_q;
  udp_pdt_pkg::res_t             res_q;
  udp_pdt_pkg::res_t             res_d;
  udp_pdt_pkg::tbl_wr_t          wr;
  logic [IdxW-1:0]               wr_idx;
  logic                          wr_gated_en;
  udp_pdt_pkg::tbl_wr_t          wr_gated;
  logic [TABLE_ENTRIES-1:0]      hit_1h;
  logic [TABLE_ENTRIES-1:0]      free_1h;
  logic [udp_pdt_pkg::DestW-1:0] hit_dest;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
      done_q     <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= req_i;
    end
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign wr_gated_en = wr.en && in_valid_q;

  always_comb begin
    wr_gated    = wr;
    wr_gated.en = wr_gated_en;
  end

  udp_pdt_table #(
    .Entries (TABLE_ENTRIES)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr_gated),
    .wr_idx_i   (wr_idx),
    .port_i     (in_q.port),
    .hit_1h_o   (hit_1h),
    .free_1h_o  (free_1h),
    .hit_dest_o (hit_dest)
  );

  udp_pdt_ctrl #(
    .Entries (TABLE_ENTRIES)
  ) u_ctrl (
    .req_i      (in_q),
    .hit_1h_i   (hit_1h),
    .free_1h_i  (free_1h),
    .hit_dest_i (hit_dest),
    .res_o      (res_d),
    .wr_o       (wr),
    .wr_idx_o   (wr_idx)
  );

  assign done_o = done_q;
  assign res_o  = res_q;

  // every accepted item yields a result strobe on done_o
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result missing for accepted item");

  // no result without an accepted item behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_valid_q))
    else $error("result strobe without item");

  // binds never store a null destination, so a delivery cannot carry one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == udp_pdt_pkg::ST_DELIVERED) |-> (res_o.destination != '0))
    else $error("delivery to null destination");

  // failed lookups report no entry and no payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status == udp_pdt_pkg::ST_FULL
             || res_o.status == udp_pdt_pkg::ST_NOT_BOUND
             || res_o.status == udp_pdt_pkg::ST_MALFORMED))
    |-> (res_o.slot == '0 && res_o.destination == '0 && res_o.payload_length == '0))
    else $error("failed item carries entry data");

endmodule

[hw/rtl/udp_pdt_table.sv]
// Binding table storage with parallel port compare and lowest-entry select.
// Depends on udp_pdt_pkg.
module udp_pdt_table #(
  parameter int unsigned Entries = 32,
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  udp_pdt_pkg::tbl_wr_t          wr_i,
  input  logic [IdxW-1:0]               wr_idx_i,
  input  logic [udp_pdt_pkg::PortW-1:0] port_i,
  output logic [Entries-1:0]            hit_1h_o,
  output logic [Entries-1:0]            free_1h_o,
  output logic [udp_pdt_pkg::DestW-1:0] hit_dest_o
);

  logic [Entries-1:0]            valid_q;
  logic [udp_pdt_pkg::PortW-1:0] port_q [Entries];
  logic [udp_pdt_pkg::DestW-1:0] dest_q [Entries];
  logic [Entries-1:0]            match;
  logic [Entries-1:0]            empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      for (int i = 0; i < Entries; i++) begin
        if (wr_idx_i == IdxW'(i)) begin
          valid_q[i] <= wr_i.valid;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      for (int i = 0; i < Entries; i++) begin
        if (wr_idx_i == IdxW'(i)) begin
          port_q[i] <= wr_i.port;
          dest_q[i] <= wr_i.dest;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      match[i] = valid_q[i] && (port_q[i] == port_i);
    end
    empty = ~valid_q;
  end

  // isolate the lowest set bit
  assign hit_1h_o  = match & (~match + Entries'(1));
  assign free_1h_o = empty & (~empty + Entries'(1));

  always_comb begin
    hit_dest_o = '0;
    for (int i = 0; i < Entries; i++) begin
      hit_dest_o = hit_dest_o | (hit_1h_o[i] ? dest_q[i] : '0);
    end
  end

endmodule

[hw/rtl/udp_pdt_ctrl.sv]
// Command decode, length checks and result build for one item.
// Depends on udp_pdt_pkg; driven by the lookup outputs of udp_pdt_table.
module udp_pdt_ctrl #(
  parameter int unsigned Entries = 32,
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  udp_pdt_pkg::req_t             req_i,
  input  logic [Entries-1:0]            hit_1h_i,
  input  logic [Entries-1:0]            free_1h_i,
  input  logic [udp_pdt_pkg::DestW-1:0] hit_dest_i,
  output udp_pdt_pkg::res_t             res_o,
  output udp_pdt_pkg::tbl_wr_t          wr_o,
  output logic [IdxW-1:0]               wr_idx_o
);

  logic            hit;
  logic            any_free;
  logic [IdxW-1:0] hit_idx;
  logic [IdxW-1:0] free_idx;
  logic            len_bad;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < Entries; i++) begin
      hit_idx  = hit_idx  | (hit_1h_i[i]  ? IdxW'(i) : '0);
      free_idx = free_idx | (free_1h_i[i] ? IdxW'(i) : '0);
    end
  end

  assign hit      = |hit_1h_i;
  assign any_free = |free_1h_i;
  assign len_bad  = (req_i.packet_length < udp_pdt_pkg::HdrBytes)
                 || (req_i.packet_length < req_i.udp_length)
                 || (req_i.udp_length < udp_pdt_pkg::HdrBytes);

  always_comb begin
    res_o        = '0;
    res_o.status = udp_pdt_pkg::ST_REJECTED;
    wr_o         = '0;
    wr_o.port    = req_i.port;
    wr_idx_o     = hit_idx;
    unique case (req_i.command)
      udp_pdt_pkg::CMD_BIND: begin
        if (req_i.port == '0 || req_i.handler_id == '0) begin
          res_o.status = udp_pdt_pkg::ST_REJECTED;
        end else if (hit || any_free) begin
          wr_idx_o     = hit ? hit_idx : free_idx;
          wr_o.en      = 1'b1;
          wr_o.valid   = 1'b1;
          wr_o.dest    = req_i.handler_id;
          res_o.status = udp_pdt_pkg::ST_BOUND;
          res_o.slot   = udp_pdt_pkg::SlotW'(wr_idx_o);
        end else begin
          res_o.status = udp_pdt_pkg::ST_FULL;
        end
      end
      udp_pdt_pkg::CMD_UNBIND: begin
        if (hit) begin
          wr_o.en      = 1'b1;
          res_o.status = udp_pdt_pkg::ST_UNBOUND;
          res_o.slot   = udp_pdt_pkg::SlotW'(hit_idx);
        end else begin
          res_o.status = udp_pdt_pkg::ST_NOT_BOUND;
        end
      end
      udp_pdt_pkg::CMD_DELIVER: begin
        if (len_bad) begin
          res_o.status = udp_pdt_pkg::ST_MALFORMED;
        end else if (hit) begin
          res_o.status          = udp_pdt_pkg::ST_DELIVERED;
          res_o.destination     = hit_dest_i;
          res_o.payload_length  = req_i.udp_length - udp_pdt_pkg::HdrBytes;
          res_o.out_src_address = req_i.src_address;
          res_o.out_sender_port = req_i.sender_port;
          res_o.slot            = udp_pdt_pkg::SlotW'(hit_idx);
        end else begin
          res_o.status = udp_pdt_pkg::ST_NOT_BOUND;
        end
      end
      default: begin
        res_o.status = udp_pdt_pkg::ST_REJECTED;
      end
    endcase
  end

endmodule
